/* rtl/core/balloc_pkg.sv */
// shared types and constants of the block allocator with data store
// no dependencies
`default_nettype none

package balloc_pkg;

   localparam int OP_W      = 3;
   localparam int ID_W      = 10;
   localparam int WI_W      = 3;
   localparam int DATA_W    = 64;
   localparam int ST_W      = 3;
   localparam int BLK_W     = 9;
   localparam int CNT_OUT_W = 10;
   localparam int MAP_W     = 32;
   localparam int POS_W     = 5;

   localparam logic [OP_W-1:0] OP_ALLOC   = 3'd0;
   localparam logic [OP_W-1:0] OP_CLAIM   = 3'd1;
   localparam logic [OP_W-1:0] OP_RELEASE = 3'd2;
   localparam logic [OP_W-1:0] OP_READ    = 3'd3;
   localparam logic [OP_W-1:0] OP_WRITE   = 3'd4;

   localparam logic [ST_W-1:0] ST_OK       = 3'd0;
   localparam logic [ST_W-1:0] ST_FULL     = 3'd1;
   localparam logic [ST_W-1:0] ST_RANGE    = 3'd2;
   localparam logic [ST_W-1:0] ST_USED     = 3'd3;
   localparam logic [ST_W-1:0] ST_NOTALLOC = 3'd4;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_SCAN_RD,
      S_SCAN_CHK,
      S_MAP_RD,
      S_MAP_CHK,
      S_DATA_RD,
      S_DONE
   } state_type;

endpackage

`default_nettype wire

/* rtl/core/balloc_req_if.sv */
// request channel of the block allocator: valid, ready and request payload
// depends on balloc_pkg
`default_nettype none

interface balloc_req_if;
   logic                             valid;
   logic                             ready;
   logic [balloc_pkg::OP_W-1:0]      operation;
   logic [balloc_pkg::ID_W-1:0]      block_num;
   logic [balloc_pkg::WI_W-1:0]      word_index;
   logic [balloc_pkg::DATA_W-1:0]    write_data;

   modport source (output valid, output operation, output block_num, output word_index,
                   output write_data, input ready);
   modport sink (input valid, input operation, input block_num, input word_index,
                 input write_data, output ready);
endinterface

`default_nettype wire

/* rtl/core/balloc_rsp_if.sv */
// response channel of the block allocator: valid, ready and response payload
// depends on balloc_pkg
`default_nettype none

interface balloc_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [balloc_pkg::ST_W-1:0]       status;
   logic [balloc_pkg::BLK_W-1:0]      result_block;
   logic [balloc_pkg::DATA_W-1:0]     read_data;
   logic [balloc_pkg::CNT_OUT_W-1:0]  used_count;
   logic [balloc_pkg::CNT_OUT_W-1:0]  free_count;

   modport source (output valid, output status, output result_block, output read_data,
                   output used_count, output free_count, input ready);
   modport sink (input valid, input status, input result_block, input read_data,
                 input used_count, input free_count, output ready);
endinterface

`default_nettype wire

/* rtl/core/block_allocator_with_store.sv */
// block allocator: allocation map ram scanned row by row, data word ram
// depends on balloc_pkg, balloc_req_if, balloc_rsp_if, balloc_ram
//
//   channel   direction  contents
//   req_chan  in         operation, block_num, word_index, write_data
//   rsp_chan  out        status, result_block, read_data, used_count, free_count
//
// one transaction at a time; the map ram holds 32 blocks per row
// allocate: reads and checks map rows in turn until a free bit or the last row;
// claim, release and write: map read, map check, response; read: map check, then
// data ram if allocated; rejected id, word or operation: straight to response
// after reset a clearing pass writes ceil(NUM_BLOCKS/32) map rows, ready low
// a response held by rsp ready low blocks the next request
`default_nettype none

module block_allocator_with_store #(
   parameter int NUM_BLOCKS      = 512,
   parameter int WORDS_PER_BLOCK = 8,
   parameter int RESERVED_FIRST  = 127,
   parameter int RESERVED_COUNT  = 1
) (
   input wire logic   clock,
   input wire logic   reset,
   balloc_req_if.sink   req_chan,
   balloc_rsp_if.source rsp_chan
);

   localparam int MAP_W      = balloc_pkg::MAP_W;
   localparam int POS_W      = balloc_pkg::POS_W;
   localparam int ID_W       = balloc_pkg::ID_W;
   localparam int DATA_W     = balloc_pkg::DATA_W;
   localparam int ST_W       = balloc_pkg::ST_W;
   localparam int OP_W       = balloc_pkg::OP_W;
   localparam int BLK_W      = balloc_pkg::BLK_W;
   localparam int CNT_OUT_W  = balloc_pkg::CNT_OUT_W;
   localparam int MAP_ROWS   = (NUM_BLOCKS + MAP_W - 1) / MAP_W;
   localparam int ROW_W      = (MAP_ROWS > 1) ? $clog2(MAP_ROWS) : 1;
   localparam int DATA_DEPTH = NUM_BLOCKS * WORDS_PER_BLOCK;
   localparam int DATA_AW    = (DATA_DEPTH > 1) ? $clog2(DATA_DEPTH) : 1;
   localparam int CNT_W      = $clog2(NUM_BLOCKS + 1);
   localparam int GRANT_W    = ROW_W + POS_W;
   localparam int RES_AVAIL  = (RESERVED_FIRST < NUM_BLOCKS) ? NUM_BLOCKS - RESERVED_FIRST : 0;
   localparam int RES_IN_POOL = (RESERVED_COUNT < RES_AVAIL) ? RESERVED_COUNT : RES_AVAIL;

   // reset image of one map row: reserved run and padding beyond the pool set
   function automatic logic [MAP_W-1:0] clear_row(input logic [ROW_W-1:0] row);
      logic [MAP_W-1:0] bits;
      int               id;
      bits = '0;
      for (int j = 0; j < MAP_W; j++) begin
         id = int'(row) * MAP_W + j;
         bits[j] = (id >= NUM_BLOCKS) ||
                   ((id >= RESERVED_FIRST) && (id < RESERVED_FIRST + RESERVED_COUNT));
      end
      return bits;
   endfunction

   balloc_pkg::state_type state_ff, state_in;

   logic [ROW_W-1:0]   clr_row_ff, clr_row_in;
   logic [ROW_W-1:0]   scan_row_ff, scan_row_in;
   logic [CNT_W-1:0]   used_ff, used_in;
   logic [OP_W-1:0]    op_ff, op_in;
   logic [ID_W-1:0]    id_ff, id_in;
   logic [DATA_W-1:0]  wdata_ff, wdata_in;
   logic [DATA_AW-1:0] daddr_ff, daddr_in;
   logic [ST_W-1:0]    status_ff, status_in;
   logic [BLK_W-1:0]   blk_ff, blk_in;
   logic [DATA_W-1:0]  rdata_ff, rdata_in;

   logic               map_wr_en, map_rd_en;
   logic [ROW_W-1:0]   map_wr_addr, map_rd_addr;
   logic [MAP_W-1:0]   map_wr_data, map_q;
   logic               data_wr_en, data_rd_en;
   logic [DATA_W-1:0]  data_q;

   logic               req_fire;
   logic               req_bad;
   logic               id_row_bad;
   logic [ROW_W-1:0]   id_row;
   logic [POS_W-1:0]   id_pos;
   logic               id_bit;
   logic               free_hit;
   logic [POS_W-1:0]   free_pos;
   logic               scan_last;
   logic [GRANT_W-1:0] grant;
   logic [GRANT_W+BLK_W-1:0] grant_ext;
   logic [CNT_W-1:0]   free_cnt;
   logic [CNT_W+CNT_OUT_W-1:0] used_ext, free_ext;
   logic               rsp_fire;

   balloc_ram #(.WIDTH(MAP_W), .DEPTH(MAP_ROWS)) u_map_ram (
      .clock   (clock),
      .wr_en   (map_wr_en),
      .wr_addr (map_wr_addr),
      .wr_data (map_wr_data),
      .rd_en   (map_rd_en),
      .rd_addr (map_rd_addr),
      .rd_data (map_q)
   );

   balloc_ram #(.WIDTH(DATA_W), .DEPTH(DATA_DEPTH)) u_data_ram (
      .clock   (clock),
      .wr_en   (data_wr_en),
      .wr_addr (daddr_ff),
      .wr_data (wdata_ff),
      .rd_en   (data_rd_en),
      .rd_addr (daddr_ff),
      .rd_data (data_q)
   );

   assign req_fire = req_chan.valid && req_chan.ready;
   assign rsp_fire = rsp_chan.valid && rsp_chan.ready;

   // request decode on the incoming payload
   always_comb begin
      logic id_oor;
      logic wi_oor;
      id_oor = 32'(req_chan.block_num) >= 32'(NUM_BLOCKS);
      wi_oor = 32'(req_chan.word_index) >= 32'(WORDS_PER_BLOCK);
      req_bad = 1'b0;
      if (req_chan.operation != balloc_pkg::OP_ALLOC) begin
         if ((req_chan.operation > balloc_pkg::OP_WRITE) || id_oor) begin
            req_bad = 1'b1;
         end else if (((req_chan.operation == balloc_pkg::OP_READ) ||
                       (req_chan.operation == balloc_pkg::OP_WRITE)) && wi_oor) begin
            req_bad = 1'b1;
         end
      end
   end

   // map lookup helpers
   assign id_row     = ROW_W'(id_ff >> POS_W);
   assign id_row_bad = 1'b0;
   assign id_pos     = id_ff[POS_W-1:0];
   assign id_bit     = map_q[id_pos] && !id_row_bad;
   assign scan_last  = 32'(scan_row_ff) == 32'(MAP_ROWS - 1);
   assign grant      = {scan_row_ff, free_pos};
   assign grant_ext  = {{BLK_W{1'b0}}, grant};

   // lowest free bit of the row just read
   always_comb begin
      free_hit = 1'b0;
      free_pos = '0;
      for (int j = MAP_W - 1; j >= 0; j--) begin
         if (!map_q[j]) begin
            free_hit = 1'b1;
            free_pos = POS_W'(j);
         end
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         balloc_pkg::S_CLEAR: begin
            if (32'(clr_row_ff) == 32'(MAP_ROWS - 1)) begin
               state_in = balloc_pkg::S_IDLE;
            end
         end
         balloc_pkg::S_IDLE: begin
            if (req_fire) begin
               if (req_chan.operation == balloc_pkg::OP_ALLOC) begin
                  state_in = balloc_pkg::S_SCAN_RD;
               end else if (req_bad) begin
                  state_in = balloc_pkg::S_DONE;
               end else begin
                  state_in = balloc_pkg::S_MAP_RD;
               end
            end
         end
         balloc_pkg::S_SCAN_RD: begin
            state_in = balloc_pkg::S_SCAN_CHK;
         end
         balloc_pkg::S_SCAN_CHK: begin
            if (free_hit || scan_last) begin
               state_in = balloc_pkg::S_DONE;
            end else begin
               state_in = balloc_pkg::S_SCAN_RD;
            end
         end
         balloc_pkg::S_MAP_RD: begin
            state_in = balloc_pkg::S_MAP_CHK;
         end
         balloc_pkg::S_MAP_CHK: begin
            if ((op_ff == balloc_pkg::OP_READ) && id_bit) begin
               state_in = balloc_pkg::S_DATA_RD;
            end else begin
               state_in = balloc_pkg::S_DONE;
            end
         end
         balloc_pkg::S_DATA_RD: begin
            state_in = balloc_pkg::S_DONE;
         end
         balloc_pkg::S_DONE: begin
            if (rsp_fire) begin
               state_in = balloc_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = balloc_pkg::S_IDLE;
         end
      endcase
   end

   // datapath and ram control
   always_comb begin
      clr_row_in  = clr_row_ff;
      scan_row_in = scan_row_ff;
      used_in     = used_ff;
      op_in       = op_ff;
      id_in       = id_ff;
      wdata_in    = wdata_ff;
      daddr_in    = daddr_ff;
      status_in   = status_ff;
      blk_in      = blk_ff;
      rdata_in    = rdata_ff;
      map_wr_en   = 1'b0;
      map_wr_addr = scan_row_ff;
      map_wr_data = map_q;
      map_rd_en   = 1'b0;
      map_rd_addr = scan_row_ff;
      data_wr_en  = 1'b0;
      data_rd_en  = 1'b0;
      unique case (state_ff)
         balloc_pkg::S_CLEAR: begin
            map_wr_en   = 1'b1;
            map_wr_addr = clr_row_ff;
            map_wr_data = clear_row(clr_row_ff);
            clr_row_in  = clr_row_ff + ROW_W'(1);
         end
         balloc_pkg::S_IDLE: begin
            if (req_fire) begin
               op_in       = req_chan.operation;
               id_in       = req_chan.block_num;
               wdata_in    = req_chan.write_data;
               daddr_in    = DATA_AW'(32'(req_chan.block_num) * 32'(WORDS_PER_BLOCK) +
                                      32'(req_chan.word_index));
               rdata_in    = '0;
               scan_row_in = '0;
               blk_in      = req_chan.block_num[BLK_W-1:0];
               status_in   = balloc_pkg::ST_OK;
               if (req_chan.operation == balloc_pkg::OP_ALLOC) begin
                  blk_in    = '0;
                  status_in = balloc_pkg::ST_FULL;
               end else if (req_bad) begin
                  status_in = balloc_pkg::ST_RANGE;
               end
            end
         end
         balloc_pkg::S_SCAN_RD: begin
            map_rd_en   = 1'b1;
            map_rd_addr = scan_row_ff;
         end
         balloc_pkg::S_SCAN_CHK: begin
            if (free_hit) begin
               map_wr_en   = 1'b1;
               map_wr_addr = scan_row_ff;
               map_wr_data = map_q | (MAP_W'(1) << free_pos);
               used_in     = used_ff + CNT_W'(1);
               status_in   = balloc_pkg::ST_OK;
               blk_in      = grant_ext[BLK_W-1:0];
            end else if (!scan_last) begin
               scan_row_in = scan_row_ff + ROW_W'(1);
            end
         end
         balloc_pkg::S_MAP_RD: begin
            map_rd_en   = 1'b1;
            map_rd_addr = id_row;
         end
         balloc_pkg::S_MAP_CHK: begin
            map_wr_addr = id_row;
            case (op_ff)
               balloc_pkg::OP_CLAIM: begin
                  if (id_bit) begin
                     status_in = balloc_pkg::ST_USED;
                  end else begin
                     map_wr_en   = 1'b1;
                     map_wr_data = map_q | (MAP_W'(1) << id_pos);
                     used_in     = used_ff + CNT_W'(1);
                  end
               end
               balloc_pkg::OP_RELEASE: begin
                  if (id_bit) begin
                     map_wr_en   = 1'b1;
                     map_wr_data = map_q & ~(MAP_W'(1) << id_pos);
                     used_in     = used_ff - CNT_W'(1);
                  end
               end
               default: begin
                  if (!id_bit) begin
                     status_in = balloc_pkg::ST_NOTALLOC;
                  end else if (op_ff == balloc_pkg::OP_READ) begin
                     data_rd_en = 1'b1;
                  end else begin
                     data_wr_en = 1'b1;
                  end
               end
            endcase
         end
         balloc_pkg::S_DATA_RD: begin
            rdata_in = data_q;
         end
         balloc_pkg::S_DONE: begin
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= balloc_pkg::S_CLEAR;
         clr_row_ff  <= '0;
         scan_row_ff <= '0;
         used_ff     <= CNT_W'(RES_IN_POOL);
      end else begin
         state_ff    <= state_in;
         clr_row_ff  <= clr_row_in;
         scan_row_ff <= scan_row_in;
         used_ff     <= used_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff     <= op_in;
      id_ff     <= id_in;
      wdata_ff  <= wdata_in;
      daddr_ff  <= daddr_in;
      status_ff <= status_in;
      blk_ff    <= blk_in;
      rdata_ff  <= rdata_in;
   end

   assign free_cnt = CNT_W'(NUM_BLOCKS) - used_ff;
   assign used_ext = {{CNT_OUT_W{1'b0}}, used_ff};
   assign free_ext = {{CNT_OUT_W{1'b0}}, free_cnt};

   assign req_chan.ready        = state_ff == balloc_pkg::S_IDLE;
   assign rsp_chan.valid        = state_ff == balloc_pkg::S_DONE;
   assign rsp_chan.status       = status_ff;
   assign rsp_chan.result_block = blk_ff;
   assign rsp_chan.read_data    = rdata_ff;
   assign rsp_chan.used_count   = used_ext[CNT_OUT_W-1:0];
   assign rsp_chan.free_count   = free_ext[CNT_OUT_W-1:0];

endmodule

`default_nettype wire

/* rtl/core/balloc_ram.sv */
// generic single-port-write, single-port-read ram with registered read data
// no dependencies
`default_nettype none

module balloc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output      logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire
